// File: src/tnsb_pkg.sv
// ----------------------------------------------------------------------------
// tnsb_pkg: shared codes and types
// Lane operation codes, shift step codes and the lane command word.
// ----------------------------------------------------------------------------
package tnsb_pkg;

	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_HALVE    = 4'd2;
	localparam logic [3:0] OP_MUL_A    = 4'd3;
	localparam logic [3:0] OP_MUL_B    = 4'd4;
	localparam logic [3:0] OP_BLEND_A  = 4'd5;
	localparam logic [3:0] OP_BLEND_B  = 4'd6;
	localparam logic [3:0] OP_DIFF     = 4'd7;
	localparam logic [3:0] OP_ADD      = 4'd8;
	localparam logic [3:0] OP_SHIFT    = 4'd9;
	localparam logic [3:0] OP_SQUARE   = 4'd10;
	localparam logic [3:0] OP_DIV_INIT = 4'd11;
	localparam logic [3:0] OP_DIV_STEP = 4'd12;
	localparam logic [3:0] OP_SAVE_N   = 4'd13;
	localparam logic [3:0] OP_SAVE_U   = 4'd14;

	localparam logic [1:0] SH_R4 = 2'd0;
	localparam logic [1:0] SH_R1 = 2'd1;
	localparam logic [1:0] SH_L4 = 2'd2;
	localparam logic [1:0] SH_L1 = 2'd3;

	localparam logic [15:0] WEIGHT_RESET = 16'd13107;
	localparam logic [3:0]  DIV_LAST     = 4'd14;

	typedef struct packed {
		logic [3:0] op;
		logic [1:0] shift;
		logic       zero;
	} lane_cmd_t;

endpackage

// File: src/tnsb_lane.sv
// ----------------------------------------------------------------------------
// tnsb_lane: one axis of the triangle datapath
// Edges, bounding box, one shared multiplier, scaling shifts and a
// bit-serial divider for the unit vector component of this axis.
// ----------------------------------------------------------------------------
module tnsb_lane (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tnsb_pkg::lane_cmd_t      cmd,
	input  logic signed [31:0]       v0,
	input  logic signed [31:0]       v1,
	input  logic signed [31:0]       v2,
	input  logic [15:0]              diffuse,
	input  logic                     wide,
	input  logic signed [31:0]       e1a,
	input  logic signed [31:0]       e2b,
	input  logic signed [31:0]       e1b,
	input  logic signed [31:0]       e2a,
	input  logic [15:0]              weight,
	input  logic [30:0]              len,
	output logic signed [31:0]       e1,
	output logic signed [31:0]       e2,
	output logic                     edge_wide,
	output logic [63:0]              mag,
	output logic [61:0]              square,
	output logic signed [15:0]       n,
	output logic signed [15:0]       u,
	output logic signed [31:0]       box_lo,
	output logic signed [31:0]       box_hi
);
	import tnsb_pkg::*;

	logic signed [32:0] e1_q, e2_q;
	logic [15:0]        diff_q;
	logic signed [65:0] prod_q, acc_q;
	logic               neg_q;
	logic [63:0]        mag_q;
	logic [46:0]        num_q, den_q;
	logic [14:0]        quo_q;
	logic signed [15:0] n_q, u_q;
	logic signed [31:0] box_lo_q, box_hi_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_c;
	logic signed [66:0] sum_c;
	logic [66:0]        abs_c;
	logic signed [15:0] res_c;
	logic signed [31:0] lo_c, hi_c;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_MUL_A: begin
				mul_a = {e1a[31], e1a};
				mul_b = {e2b[31], e2b};
			end
			OP_MUL_B: begin
				mul_a = {e1b[31], e1b};
				mul_b = {e2a[31], e2a};
			end
			OP_BLEND_A: begin
				mul_a = {{15{n_q[15]}}, n_q, 2'b00};
				mul_b = {17'b0, weight};
			end
			OP_BLEND_B: begin
				mul_a = {17'b0, diff_q};
				mul_b = {16'b0, 17'h10000 - {1'b0, weight}};
			end
			OP_SQUARE: begin
				mul_a = {3'b0, mag_q[29:0]};
				mul_b = {3'b0, mag_q[29:0]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;
	assign sum_c  = (cmd.op == OP_ADD) ? ({acc_q[65], acc_q} + {prod_q[65], prod_q})
	                                   : ({acc_q[65], acc_q} - {prod_q[65], prod_q});
	assign abs_c  = sum_c[66] ? 67'(-sum_c) : 67'(sum_c);
	assign res_c  = cmd.zero ? 16'sd0 : (neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q}));

	always_comb begin
		lo_c = box_lo_q;
		hi_c = box_hi_q;
		if (v0 < lo_c) lo_c = v0;
		if (v1 < lo_c) lo_c = v1;
		if (v2 < lo_c) lo_c = v2;
		if (v0 > hi_c) hi_c = v0;
		if (v1 > hi_c) hi_c = v1;
		if (v2 > hi_c) hi_c = v2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lo_q <= 32'sh7FFFFFFF;
			box_hi_q <= 32'sh80000000;
		end else if (cmd.op == OP_LOAD) begin
			box_lo_q <= lo_c;
			box_hi_q <= hi_c;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				e1_q   <= {v1[31], v1} - {v0[31], v0};
				e2_q   <= {v2[31], v2} - {v0[31], v0};
				diff_q <= diffuse;
			end
			OP_HALVE: begin
				if (wide) begin
					e1_q <= e1_q >>> 1;
					e2_q <= e2_q >>> 1;
				end
			end
			OP_MUL_A, OP_BLEND_A, OP_SQUARE: begin
				prod_q <= prod_c;
			end
			OP_MUL_B, OP_BLEND_B: begin
				prod_q <= prod_c;
				acc_q  <= prod_q;
			end
			OP_DIFF, OP_ADD: begin
				neg_q <= sum_c[66];
				mag_q <= abs_c[63:0];
			end
			OP_SHIFT: begin
				case (cmd.shift)
					SH_R4:   mag_q <= mag_q >> 4;
					SH_R1:   mag_q <= mag_q >> 1;
					SH_L4:   mag_q <= mag_q << 4;
					SH_L1:   mag_q <= mag_q << 1;
					default: mag_q <= mag_q;
				endcase
			end
			OP_DIV_INIT: begin
				num_q <= {2'b0, mag_q[29:0], 15'b0} + {16'b0, len};
				den_q <= {1'b0, len, 15'b0};
				quo_q <= '0;
			end
			OP_DIV_STEP: begin
				if (num_q >= den_q) begin
					num_q <= num_q - den_q;
					quo_q <= {quo_q[13:0], 1'b1};
				end else begin
					quo_q <= {quo_q[13:0], 1'b0};
				end
				den_q <= den_q >> 1;
			end
			OP_SAVE_N: n_q <= res_c;
			OP_SAVE_U: u_q <= res_c;
			default: begin
			end
		endcase
	end

	assign e1        = e1_q[31:0];
	assign e2        = e2_q[31:0];
	assign edge_wide = (e1_q[32] != e1_q[31]) || (e2_q[32] != e2_q[31]);
	assign mag       = mag_q;
	assign square    = prod_q[61:0];
	assign n         = n_q;
	assign u         = u_q;
	assign box_lo    = box_lo_q;
	assign box_hi    = box_hi_q;

endmodule

// File: src/tnsb_isqrt.sv
// ----------------------------------------------------------------------------
// tnsb_isqrt: iterative integer square root
// Floor square root of a 62-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tnsb_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [61:0] x,
	output logic        done,
	output logic [30:0] root
);
	import tnsb_pkg::*;

	logic [61:0] rem_q, res_q, bit_q;
	logic        busy_q, done_q;
	logic [62:0] trial_c;

	assign trial_c = {1'b0, res_q} + {1'b0, bit_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			busy_q <= !bit_q[0];
			done_q <= bit_q[0];
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= x;
			res_q <= '0;
			bit_q <= {2'b01, 60'b0};
		end else if (busy_q) begin
			if ({1'b0, rem_q} >= trial_c) begin
				rem_q <= rem_q - trial_c[61:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[30:0];

endmodule

// File: src/triangle_normal_shade_bbox_unit.sv
// ----------------------------------------------------------------------------
// triangle_normal_shade_bbox_unit: face normal, tinted color, running box
// Three axis lanes under one sequencer with a shared square root unit.
// ----------------------------------------------------------------------------
// One triangle is taken at a time and runs from acceptance to the output
// register through the load, conditional halve, first and second product
// and cross product states, then the unit-length scaling runs twice
// (normal, then blend, with the BLEND_A, BLEND_B and BLEND states between).
// Each run holds normalizing shifts, a square and a sum step, the iterative
// square root with its done strobe, a bit-serial divide in every lane and
// a save. A zero normal or a zero blend skips the rest of its run.
// A finished beat waits in the output register while the next triangle is
// taken. The bounding box is updated as each triangle is accepted and
// returned with its result.
module triangle_normal_shade_bbox_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// v0_x v0_y v0_z v1_x v1_y v1_z v2_x v2_y v2_z diffuse_r diffuse_g diffuse_b
	input  logic [335:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x normal_y normal_z color_r color_g color_b
	// box_min_x box_min_y box_min_z box_max_x box_max_y box_max_z
	output logic [287:0] m_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);
	import tnsb_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_HALVE   = 4'd1;
	localparam logic [3:0] ST_MUL_A   = 4'd2;
	localparam logic [3:0] ST_MUL_B   = 4'd3;
	localparam logic [3:0] ST_CROSS   = 4'd4;
	localparam logic [3:0] ST_SHIFT   = 4'd5;
	localparam logic [3:0] ST_SUM     = 4'd6;
	localparam logic [3:0] ST_SQRT    = 4'd7;
	localparam logic [3:0] ST_DIV     = 4'd8;
	localparam logic [3:0] ST_SAVE    = 4'd9;
	localparam logic [3:0] ST_BLEND_A = 4'd10;
	localparam logic [3:0] ST_BLEND_B = 4'd11;
	localparam logic [3:0] ST_BLEND   = 4'd12;
	localparam logic [3:0] ST_OUT     = 4'd13;

	logic [3:0]   state_q, state_d;
	logic [3:0]   cnt_q;
	logic         pass_q;
	logic [15:0]  weight_q;
	logic         m_tvalid_q;
	logic [287:0] m_tdata_q;

	lane_cmd_t          cmd;
	logic signed [31:0] e1_w [3];
	logic signed [31:0] e2_w [3];
	logic               wide_w [3];
	logic [63:0]        mag_w [3];
	logic [61:0]        sq_w [3];
	logic signed [15:0] n_w [3];
	logic signed [15:0] u_w [3];
	logic signed [31:0] lo_w [3];
	logic signed [31:0] hi_w [3];

	logic [63:0]  big_c;
	logic [61:0]  len2_c;
	logic         sqrt_start, sqrt_done;
	logic [30:0]  root;
	logic         out_load;
	logic [47:0]  color_c;

	function automatic logic [15:0] shade(input logic signed [15:0] v);
		logic signed [17:0] c;
		c = 18'sd32768 + {v[15], v, 1'b0};
		return c[16] ? 16'hFFFF : c[15:0];
	endfunction

	genvar k;
	for (k = 0; k < 3; k++) begin : g_lane
		localparam int A = (k + 1) % 3;
		localparam int B = (k + 2) % 3;
		tnsb_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.v0        (s_tdata[32*k +: 32]),
			.v1        (s_tdata[96 + 32*k +: 32]),
			.v2        (s_tdata[192 + 32*k +: 32]),
			.diffuse   (s_tdata[288 + 16*k +: 16]),
			.wide      (wide_w[0] | wide_w[1] | wide_w[2]),
			.e1a       (e1_w[A]),
			.e2b       (e2_w[B]),
			.e1b       (e1_w[B]),
			.e2a       (e2_w[A]),
			.weight    (weight_q),
			.len       (root),
			.e1        (e1_w[k]),
			.e2        (e2_w[k]),
			.edge_wide (wide_w[k]),
			.mag       (mag_w[k]),
			.square    (sq_w[k]),
			.n         (n_w[k]),
			.u         (u_w[k]),
			.box_lo    (lo_w[k]),
			.box_hi    (hi_w[k])
		);
		assign color_c[16*k +: 16] = shade(u_w[k]);
	end

	tnsb_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (len2_c),
		.done   (sqrt_done),
		.root   (root)
	);

	always_comb begin
		big_c = mag_w[0];
		if (mag_w[1] > big_c) big_c = mag_w[1];
		if (mag_w[2] > big_c) big_c = mag_w[2];
	end

	assign len2_c     = sq_w[0] + sq_w[1] + sq_w[2];
	assign sqrt_start = (state_q == ST_SUM);
	assign s_tready   = (state_q == ST_IDLE);
	assign out_load   = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.shift = SH_R1;
		cmd.zero  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_HALVE;
				end
			end
			ST_HALVE: begin
				cmd.op  = OP_HALVE;
				state_d = ST_MUL_A;
			end
			ST_MUL_A: begin
				cmd.op  = OP_MUL_A;
				state_d = ST_MUL_B;
			end
			ST_MUL_B: begin
				cmd.op  = OP_MUL_B;
				state_d = ST_CROSS;
			end
			ST_CROSS: begin
				cmd.op  = OP_DIFF;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				if (big_c == '0) begin
					cmd.op   = pass_q ? OP_SAVE_U : OP_SAVE_N;
					cmd.zero = 1'b1;
					state_d  = pass_q ? ST_OUT : ST_BLEND_A;
				end else if (|big_c[63:34]) begin
					cmd.op    = OP_SHIFT;
					cmd.shift = SH_R4;
				end else if (|big_c[63:30]) begin
					cmd.op    = OP_SHIFT;
					cmd.shift = SH_R1;
				end else if (!(|big_c[63:25])) begin
					cmd.op    = OP_SHIFT;
					cmd.shift = SH_L4;
				end else if (!(|big_c[63:29])) begin
					cmd.op    = OP_SHIFT;
					cmd.shift = SH_L1;
				end else begin
					cmd.op  = OP_SQUARE;
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					cmd.op  = OP_DIV_INIT;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == DIV_LAST) state_d = ST_SAVE;
			end
			ST_SAVE: begin
				cmd.op  = pass_q ? OP_SAVE_U : OP_SAVE_N;
				state_d = pass_q ? ST_OUT : ST_BLEND_A;
			end
			ST_BLEND_A: begin
				cmd.op  = OP_BLEND_A;
				state_d = ST_BLEND_B;
			end
			ST_BLEND_B: begin
				cmd.op  = OP_BLEND_B;
				state_d = ST_BLEND;
			end
			ST_BLEND: begin
				cmd.op  = OP_ADD;
				state_d = ST_SHIFT;
			end
			ST_OUT: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pass_q     <= 1'b0;
			weight_q   <= WEIGHT_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) weight_q <= cfg_data;
			if (state_q == ST_IDLE) pass_q <= 1'b0;
			else if (cmd.op == OP_SAVE_N) pass_q <= 1'b1;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 4'd1;
			else cnt_q <= '0;
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {hi_w[2], hi_w[1], hi_w[0], lo_w[2], lo_w[1], lo_w[0],
			              color_c, n_w[2], n_w[1], n_w[0]};
		end
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

endmodule
